// ===== rtl/rpac_pkg.sv =====
// Shared constants, angle table and pipeline sideband types for the point rotator.
`default_nettype none

package rpac_pkg;

    // Default values for top-level parameters
    localparam int ITERATIONS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // Direction vector prescale and vectoring datapath width
    localparam int DIR_SCALE_BITS = 28;
    localparam int VEC_W          = 32 + DIR_SCALE_BITS + 3;

    // Angles are unsigned turns, 2^32 per turn
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;
    localparam logic [31:0] ANG_ROUND = 32'h0000_8000;

    // CORDIC gain 0.6072529350 in Q0.32
    localparam logic [31:0] GAIN_Q32  = 32'd2608131496;

    // Saturation bounds
    localparam logic [31:0] SAT_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN   = 32'h8000_0000;

    // round(atan(2^-i) * 2^32 / (2*pi))
    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] v;
        unique case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458908;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // Sideband carried through the vectoring cells
    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic               use_dir;
        logic [15:0]        rot_angle;
        logic               zero_dir;
    } t_vside;

    // Sideband carried through the rotation cells
    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
    } t_rside;

endpackage

`default_nettype wire

// ===== rtl/rpac_vec_cell.sv =====
// One vectoring CORDIC cell: steers the direction vector toward the x axis.
`default_nettype none

module rpac_vec_cell
    import rpac_pkg::*;
#(
    parameter int STAGE = 0,
    parameter int W     = VEC_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic signed [W-1:0] i_x,
    input  logic signed [W-1:0] i_y,
    input  logic [31:0]         i_acc,
    input  t_vside              i_side,
    output logic                o_valid,
    output logic signed [W-1:0] o_x,
    output logic signed [W-1:0] o_y,
    output logic [31:0]         o_acc,
    output t_vside              o_side
);

    localparam logic [31:0] ANGLE = atan_turn(STAGE);

    logic signed [W-1:0] xs;
    logic signed [W-1:0] ys;
    logic signed [W-1:0] n_x;
    logic signed [W-1:0] n_y;
    logic [31:0]         n_acc;

    logic                r_valid;
    logic signed [W-1:0] r_x;
    logic signed [W-1:0] r_y;
    logic [31:0]         r_acc;
    t_vside              r_side;

    // Micro-rotation: turn clockwise while y is non-negative
    always_comb begin
        xs = i_x >>> STAGE;
        ys = i_y >>> STAGE;
        if (!i_y[W-1]) begin
            n_x   = i_x + ys;
            n_y   = i_y - xs;
            n_acc = i_acc + ANGLE;
        end else begin
            n_x   = i_x - ys;
            n_y   = i_y + xs;
            n_acc = i_acc - ANGLE;
        end
    end

    // Track request presence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_acc  <= n_acc;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_acc   = r_acc;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// ===== rtl/rpac_rot_cell.sv =====
// One rotation CORDIC cell: turns the offset vector and drives the residual angle to zero.
`default_nettype none

module rpac_rot_cell
    import rpac_pkg::*;
#(
    parameter int STAGE = 0,
    parameter int W     = 52
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic signed [W-1:0] i_x,
    input  logic signed [W-1:0] i_y,
    input  logic [31:0]         i_z,
    input  t_rside              i_side,
    output logic                o_valid,
    output logic signed [W-1:0] o_x,
    output logic signed [W-1:0] o_y,
    output logic [31:0]         o_z,
    output t_rside              o_side
);

    localparam logic [31:0] ANGLE = atan_turn(STAGE);

    logic signed [W-1:0] xs;
    logic signed [W-1:0] ys;
    logic signed [W-1:0] n_x;
    logic signed [W-1:0] n_y;
    logic [31:0]         n_z;

    logic                r_valid;
    logic signed [W-1:0] r_x;
    logic signed [W-1:0] r_y;
    logic [31:0]         r_z;
    t_rside              r_side;

    // Micro-rotation: turn counter-clockwise while the residual is non-negative
    always_comb begin
        xs = i_x >>> STAGE;
        ys = i_y >>> STAGE;
        if (!i_z[31]) begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - ANGLE;
        end else begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + ANGLE;
        end
    end

    // Track request presence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// ===== rtl/rpac_finish.sv =====
// Gain compensation, descale, center add and saturation for one coordinate (four stages).
`default_nettype none

module rpac_finish
    import rpac_pkg::*;
#(
    parameter int W         = 52,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [W-1:0] i_v,
    input  logic signed [31:0]  i_center,
    output logic [31:0]         o_val,
    output logic                o_hit
);

    localparam int MH_W = W - 32;
    localparam int P_W  = W + 1;
    localparam int Q_W  = W + 2 - FRAC_BITS;
    localparam int S_W  = Q_W + 2;

    localparam logic [P_W:0] Q_ROUND = (P_W+1)'(1) << (FRAC_BITS - 1);
    localparam logic [64:0]  P_ROUND = 65'h0_8000_0000;

    // Stage 1: magnitude
    logic [W-1:0]        n_m;
    logic [W-1:0]        r_m;
    logic                r_neg1;
    logic signed [31:0]  r_c1;

    // Stage 2: partial products
    logic [MH_W-1:0]     mh_ext;
    logic [W-1:0]        n_ph;
    logic [63:0]         n_pl;
    logic [W-1:0]        r_ph;
    logic [63:0]         r_pl;
    logic                r_neg2;
    logic signed [31:0]  r_c2;

    // Stage 3: scaled and rounded magnitude
    logic [64:0]         pl_sum;
    logic [P_W-1:0]      p_sum;
    logic [P_W:0]        q_sum;
    logic [Q_W-1:0]      n_q;
    logic [Q_W-1:0]      r_q;
    logic                r_neg3;
    logic signed [31:0]  r_c3;

    // Stage 4: signed result, saturated
    logic signed [Q_W:0] sq;
    logic signed [S_W-1:0] sum;
    logic [S_W-32:0]     hi;
    logic [31:0]         n_val;
    logic                n_hit;
    logic [31:0]         r_val;
    logic                r_hit;

    // Take magnitude so rounding is symmetric about zero
    assign n_m = i_v[W-1] ? W'(-i_v) : W'(i_v);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m    <= n_m;
            r_neg1 <= i_v[W-1];
            r_c1   <= i_center;
        end
    end

    // Multiply high and low halves by the gain
    always_comb begin
        mh_ext = r_m[W-1:32];
        n_ph   = {{32{1'b0}}, mh_ext} * {{MH_W{1'b0}}, GAIN_Q32};
        n_pl   = {32'b0, r_m[31:0]} * {32'b0, GAIN_Q32};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ph   <= n_ph;
            r_pl   <= n_pl;
            r_neg2 <= r_neg1;
            r_c2   <= r_c1;
        end
    end

    // Combine halves, drop fraction bits with round half up
    always_comb begin
        pl_sum = {1'b0, r_pl} + P_ROUND;
        p_sum  = {1'b0, r_ph} + P_W'(pl_sum[64:32]);
        q_sum  = {1'b0, p_sum} + Q_ROUND;
        n_q    = q_sum[P_W:FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q    <= n_q;
            r_neg3 <= r_neg2;
            r_c3   <= r_c2;
        end
    end

    // Restore sign, add center, clip to 32 bits
    always_comb begin
        sq    = r_neg3 ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
        sum   = S_W'(sq) + S_W'(r_c3);
        hi    = sum[S_W-1:31];
        n_hit = !((&hi) || !(|hi));
        if (!n_hit) begin
            n_val = sum[31:0];
        end else if (sum[S_W-1]) begin
            n_val = SAT_MIN;
        end else begin
            n_val = SAT_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val <= n_val;
            r_hit <= n_hit;
        end
    end

    assign o_val = r_val;
    assign o_hit = r_hit;

endmodule

`default_nettype wire

// ===== rtl/rotate_point_about_center.sv =====
// Throughput: one request per cycle while the output is not stalled; an input register,
// a chain of vectoring cells, a fold register, a chain of rotation cells, then a four-stage
// gain and saturation unit, all advancing together.
// A stalled result freezes the whole chain; input ready is low only while a result is held.
// Synchronous active-low reset clears every stage's valid flag; payload is not reset.
`default_nettype none

module rotate_point_about_center
    import rpac_pkg::*;
#(
    parameter int ITERATIONS = ITERATIONS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_center_x,
    input  logic signed [31:0] i_center_y,
    input  logic               i_use_direction,
    input  logic signed [15:0] i_rot_angle,
    input  logic signed [31:0] i_dir_x,
    input  logic signed [31:0] i_dir_y,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic               o_saturated
);

    localparam int ROT_W  = 36 + FRAC_BITS;
    localparam int FIN_ST = 4;

    logic en;

    // Input stage
    logic               r_in_valid;
    t_vside             r_in_side;
    logic signed [31:0] r_in_dir_x;
    logic signed [31:0] r_in_dir_y;
    t_vside             n_in_side;

    // Vectoring chain
    logic                    v_valid [0:ITERATIONS];
    logic signed [VEC_W-1:0] v_x     [0:ITERATIONS];
    logic signed [VEC_W-1:0] v_y     [0:ITERATIONS];
    logic [31:0]             v_acc   [0:ITERATIONS];
    t_vside                  v_side  [0:ITERATIONS];
    logic signed [VEC_W-1:0] dir_x_s;
    logic signed [VEC_W-1:0] dir_y_s;

    // Quadrant fold stage
    logic [31:0]             acc_rnd;
    logic [15:0]             ang;
    logic [31:0]             mid_z;
    logic signed [32:0]      d_x;
    logic signed [32:0]      d_y;
    logic signed [32:0]      nd_x;
    logic signed [32:0]      nd_y;
    logic                    fold;
    logic signed [ROT_W-1:0] n_mid_x;
    logic signed [ROT_W-1:0] n_mid_y;
    logic [31:0]             n_mid_z;
    t_rside                  n_mid_side;
    logic                    r_mid_valid;
    logic signed [ROT_W-1:0] r_mid_x;
    logic signed [ROT_W-1:0] r_mid_y;
    logic [31:0]             r_mid_z;
    t_rside                  r_mid_side;

    // Rotation chain
    logic                    r_valid_c [0:ITERATIONS];
    logic signed [ROT_W-1:0] rc_x      [0:ITERATIONS];
    logic signed [ROT_W-1:0] rc_y      [0:ITERATIONS];
    logic [31:0]             rc_z      [0:ITERATIONS];
    t_rside                  rc_side   [0:ITERATIONS];

    // Finish stages
    logic [FIN_ST-1:0] r_fin_valid;
    logic [31:0]       fin_x;
    logic [31:0]       fin_y;
    logic              hit_x;
    logic              hit_y;

    // Whole chain moves unless a finished result is held
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // Capture request
    always_comb begin
        n_in_side.point_x   = i_point_x;
        n_in_side.point_y   = i_point_y;
        n_in_side.center_x  = i_center_x;
        n_in_side.center_y  = i_center_y;
        n_in_side.use_dir   = i_use_direction;
        n_in_side.rot_angle = i_rot_angle;
        n_in_side.zero_dir  = (i_dir_x == 32'sd0) && (i_dir_y == 32'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_side  <= n_in_side;
            r_in_dir_x <= i_dir_x;
            r_in_dir_y <= i_dir_y;
        end
    end

    // Scale direction vector, fold left half-plane onto the right
    assign dir_x_s    = {{(VEC_W-32-DIR_SCALE_BITS){r_in_dir_x[31]}}, r_in_dir_x,
                         {DIR_SCALE_BITS{1'b0}}};
    assign dir_y_s    = {{(VEC_W-32-DIR_SCALE_BITS){r_in_dir_y[31]}}, r_in_dir_y,
                         {DIR_SCALE_BITS{1'b0}}};
    assign v_valid[0] = r_in_valid;
    assign v_side[0]  = r_in_side;
    assign v_x[0]     = r_in_dir_x[31] ? -dir_x_s : dir_x_s;
    assign v_y[0]     = r_in_dir_x[31] ? -dir_y_s : dir_y_s;
    assign v_acc[0]   = r_in_dir_x[31] ? HALF_TURN : 32'd0;

    genvar gi;
    generate
        for (gi = 0; gi < ITERATIONS; gi++) begin : g_vec
            rpac_vec_cell #(
                .STAGE (gi),
                .W     (VEC_W)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en),
                .i_valid (v_valid[gi]),
                .i_x     (v_x[gi]),
                .i_y     (v_y[gi]),
                .i_acc   (v_acc[gi]),
                .i_side  (v_side[gi]),
                .o_valid (v_valid[gi+1]),
                .o_x     (v_x[gi+1]),
                .o_y     (v_y[gi+1]),
                .o_acc   (v_acc[gi+1]),
                .o_side  (v_side[gi+1])
            );
        end
    endgenerate

    // Pick angle source, form offset from center, fold target into the right half
    always_comb begin
        acc_rnd = v_acc[ITERATIONS] + ANG_ROUND;
        if (!v_side[ITERATIONS].use_dir) begin
            ang = v_side[ITERATIONS].rot_angle;
        end else if (v_side[ITERATIONS].zero_dir) begin
            ang = 16'd0;
        end else begin
            ang = acc_rnd[31:16];
        end
        mid_z = {ang, 16'b0};
        fold  = (mid_z[31:30] == 2'b01) || (mid_z[31:30] == 2'b10);
        d_x   = 33'(v_side[ITERATIONS].point_x) - 33'(v_side[ITERATIONS].center_x);
        d_y   = 33'(v_side[ITERATIONS].point_y) - 33'(v_side[ITERATIONS].center_y);
        nd_x  = 33'(v_side[ITERATIONS].center_x) - 33'(v_side[ITERATIONS].point_x);
        nd_y  = 33'(v_side[ITERATIONS].center_y) - 33'(v_side[ITERATIONS].point_y);
        if (fold) begin
            n_mid_x = {{3{nd_x[32]}}, nd_x, {FRAC_BITS{1'b0}}};
            n_mid_y = {{3{nd_y[32]}}, nd_y, {FRAC_BITS{1'b0}}};
            n_mid_z = mid_z - HALF_TURN;
        end else begin
            n_mid_x = {{3{d_x[32]}}, d_x, {FRAC_BITS{1'b0}}};
            n_mid_y = {{3{d_y[32]}}, d_y, {FRAC_BITS{1'b0}}};
            n_mid_z = mid_z;
        end
        n_mid_side.center_x = v_side[ITERATIONS].center_x;
        n_mid_side.center_y = v_side[ITERATIONS].center_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
        end else if (en) begin
            r_mid_valid <= v_valid[ITERATIONS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mid_x    <= n_mid_x;
            r_mid_y    <= n_mid_y;
            r_mid_z    <= n_mid_z;
            r_mid_side <= n_mid_side;
        end
    end

    assign r_valid_c[0] = r_mid_valid;
    assign rc_x[0]      = r_mid_x;
    assign rc_y[0]      = r_mid_y;
    assign rc_z[0]      = r_mid_z;
    assign rc_side[0]   = r_mid_side;

    generate
        for (gi = 0; gi < ITERATIONS; gi++) begin : g_rot
            rpac_rot_cell #(
                .STAGE (gi),
                .W     (ROT_W)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en),
                .i_valid (r_valid_c[gi]),
                .i_x     (rc_x[gi]),
                .i_y     (rc_y[gi]),
                .i_z     (rc_z[gi]),
                .i_side  (rc_side[gi]),
                .o_valid (r_valid_c[gi+1]),
                .o_x     (rc_x[gi+1]),
                .o_y     (rc_y[gi+1]),
                .o_z     (rc_z[gi+1]),
                .o_side  (rc_side[gi+1])
            );
        end
    endgenerate

    // Advance finish-stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= '0;
        end else if (en) begin
            r_fin_valid <= {r_fin_valid[FIN_ST-2:0], r_valid_c[ITERATIONS]};
        end
    end

    rpac_finish #(
        .W         (ROT_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_fin_x (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_v      (rc_x[ITERATIONS]),
        .i_center (rc_side[ITERATIONS].center_x),
        .o_val    (fin_x),
        .o_hit    (hit_x)
    );

    rpac_finish #(
        .W         (ROT_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_fin_y (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_v      (rc_y[ITERATIONS]),
        .i_center (rc_side[ITERATIONS].center_y),
        .o_val    (fin_y),
        .o_hit    (hit_y)
    );

    assign o_out_valid = r_fin_valid[FIN_ST-1];
    assign o_out_x     = fin_x;
    assign o_out_y     = fin_y;
    assign o_saturated = hit_x || hit_y;

`ifndef SYNTH
    // Reset empties the result stage
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Clipped result must sit on a bound
    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
            (o_out_x == SAT_MAX || o_out_x == SAT_MIN ||
             o_out_y == SAT_MAX || o_out_y == SAT_MIN))
        else $error("saturated flag without clipped coordinate");

    // Folded target lies within a quarter turn of zero
    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mid_valid |-> (r_mid_z[31:30] == 2'b00 || r_mid_z[31:30] == 2'b11))
        else $error("rotation target outside folded range");
`endif

endmodule

`default_nettype wire
